[hdl/kmcu_pkg.sv]
// ----------------------------------------------------------------------------
// kmcu_pkg: shared types and constants for the k-means center update block
// Opcodes, default sizes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package kmcu_pkg;

   localparam int DefMaxClusters = 16;
   localparam int DefMaxPoints   = 65536;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;   // unused code, accepted and ignored

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear;       // clear sums and count of the walked cluster
      logic div_start;   // launch division for the walked cluster
      logic emit;        // present result for the walked cluster
   } kmcu_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic div_done;
   } kmcu_status_type;

endpackage

[hdl/kmcu_divider.sv]
// ----------------------------------------------------------------------------
// kmcu_divider: signed divide, one quotient bit per cycle
// Restoring division of a signed sum by a positive count, truncating.
// ----------------------------------------------------------------------------
module kmcu_divider #(
   parameter int NW = 48,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] numer,
   input  logic [DW-1:0] denom,
   output logic          done,
   output logic [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   // one shift-subtract step a cycle
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      diff  = trial - {1'b0, d_ff};
      if (start) begin
         neg_in  = numer[NW-1];
         q_in    = numer[NW-1] ? (~numer + 1'b1) : numer;
         r_in    = '0;
         d_in    = denom;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            r_in = diff;
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = neg_ff ? (~q_ff + 1'b1) : q_ff;
endmodule

[hdl/kmcu_datapath.sv]
// ----------------------------------------------------------------------------
// kmcu_datapath: center, sum and count storage with two dividers
// Adds points one per cycle unless busy; forms results on controller command.
// ----------------------------------------------------------------------------
module kmcu_datapath #(
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_POINTS   = 65536,
   parameter int IW           = $clog2(MAX_CLUSTERS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_xfer,
   input  logic [1:0]            req_opcode,
   input  logic [5:0]            req_cluster_index,
   input  logic signed [31:0]    req_coord_x,
   input  logic signed [31:0]    req_coord_y,
   input  logic [IW-1:0]         walk_idx,
   input  kmcu_pkg::kmcu_cmd_type cmd,
   output kmcu_pkg::kmcu_status_type status,
   output logic signed [31:0]    rsp_center_x,
   output logic signed [31:0]    rsp_center_y,
   output logic                  rsp_center_changed,
   output logic                  rsp_cluster_empty
);
   import kmcu_pkg::*;

   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam int SW   = 32 + CNTW;

   logic signed [31:0] cx_ff [MAX_CLUSTERS];
   logic signed [31:0] cy_ff [MAX_CLUSTERS];
   logic [SW-1:0]      sx_ff [MAX_CLUSTERS];
   logic [SW-1:0]      sy_ff [MAX_CLUSTERS];
   logic [CNTW-1:0]    n_ff  [MAX_CLUSTERS];
   logic               in_range;
   logic [IW-1:0]      idx;
   logic [SW-1:0]      qx, qy;
   logic               dx_done, dy_done;
   logic [31:0]        nx, ny;
   logic               empty;

   assign in_range = ({1'b0, req_cluster_index} < 7'(MAX_CLUSTERS));
   assign idx      = req_cluster_index[IW-1:0];
   assign empty    = (n_ff[walk_idx] == '0);
   assign nx       = qx[31:0];
   assign ny       = qy[31:0];

   kmcu_divider #(.NW(SW), .DW(CNTW)) u_div_x (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .numer(sx_ff[walk_idx]), .denom(n_ff[walk_idx]), .done(dx_done), .quot(qx));
   kmcu_divider #(.NW(SW), .DW(CNTW)) u_div_y (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .numer(sy_ff[walk_idx]), .denom(n_ff[walk_idx]), .done(dy_done), .quot(qy));

   assign status.div_done = dx_done & dy_done;

   // storage updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            cx_ff[i] <= '0; cy_ff[i] <= '0;
            sx_ff[i] <= '0; sy_ff[i] <= '0; n_ff[i] <= '0;
         end
      end else begin
         if (in_xfer && in_range && req_opcode == OP_LOAD) begin
            cx_ff[idx] <= req_coord_x;
            cy_ff[idx] <= req_coord_y;
         end
         if (in_xfer && in_range && req_opcode == OP_ADD &&
             n_ff[idx] < CNTW'(MAX_POINTS)) begin
            sx_ff[idx] <= sx_ff[idx] + SW'(req_coord_x);
            sy_ff[idx] <= sy_ff[idx] + SW'(req_coord_y);
            n_ff[idx]  <= n_ff[idx] + 1'b1;
         end
         if (cmd.emit && !empty) begin
            cx_ff[walk_idx] <= nx;
            cy_ff[walk_idx] <= ny;
         end
         if (cmd.clear) begin
            sx_ff[walk_idx] <= '0; sy_ff[walk_idx] <= '0; n_ff[walk_idx] <= '0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_cluster_empty  <= empty;
         rsp_center_x       <= empty ? cx_ff[walk_idx] : nx;
         rsp_center_y       <= empty ? cy_ff[walk_idx] : ny;
         rsp_center_changed <= !empty &&
            (nx != cx_ff[walk_idx] || ny != cy_ff[walk_idx]);
      end
   end
endmodule

[hdl/kmcu_control.sv]
// ----------------------------------------------------------------------------
// kmcu_control: finish sequencer
// Walks all stored clusters, dividing and emitting those in use, clearing all.
// ----------------------------------------------------------------------------
module kmcu_control #(
   parameter int MAX_CLUSTERS = 16,
   parameter int IW           = $clog2(MAX_CLUSTERS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   finish,
   input  logic [6:0]             num_clusters,
   input  kmcu_pkg::kmcu_status_type status,
   output kmcu_pkg::kmcu_cmd_type cmd,
   output logic [IW-1:0]          walk_idx,
   output logic                   busy,
   output logic                   rsp_valid,
   output logic [5:0]             rsp_result_cluster,
   output logic                   rsp_last_result
);
   import kmcu_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIV  = 4'b0010,
      S_WAIT = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type     st_ff, st_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [6:0]    k_ff, k_in;
   logic          in_use, last_use, last_idx;
   logic          v_ff, v_in;

   assign in_use   = (7'(idx_ff) < k_ff);
   assign last_use = (7'(idx_ff) + 7'd1 == k_ff);
   assign last_idx = (idx_ff == IW'(MAX_CLUSTERS - 1));

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; k_in = k_ff; cmd = '0; v_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (finish) begin
               idx_in = '0;
               if (num_clusters == 7'd0) k_in = 7'd1;
               else if (num_clusters > 7'(MAX_CLUSTERS)) k_in = 7'(MAX_CLUSTERS);
               else k_in = num_clusters;
               st_in = S_DIV;
            end
         end
         S_DIV: begin
            if (in_use) begin
               cmd.div_start = 1'b1;
               st_in = S_WAIT;
            end else begin
               cmd.clear = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (last_idx) st_in = S_IDLE;
            end
         end
         S_WAIT: begin
            if (status.div_done) st_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1; cmd.clear = 1'b1; v_in = 1'b1;
            idx_in = idx_ff + 1'b1;
            st_in = last_idx ? S_IDLE : S_DIV;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; k_ff <= k_in;
      if (v_in) begin
         rsp_result_cluster <= 6'(idx_ff);
         rsp_last_result    <= last_use;
      end
      if (reset) begin
         st_ff <= S_IDLE;
         v_ff  <= 1'b0;
      end else begin
         st_ff <= st_in;
         v_ff  <= v_in;
      end
   end

   assign walk_idx  = idx_ff;
   assign busy      = (st_ff != S_IDLE);
   assign rsp_valid = v_ff;
endmodule

[hdl/kmeans_centroid_update.sv]
// ----------------------------------------------------------------------------
// kmeans_centroid_update: two-dimensional k-means center update
// Load and add items are accepted back to back while busy is low.
// A finish item walks all MAX_CLUSTERS slots: clusters in use go through
// the bit-serial dividers and are emitted, others only cleared; busy is high.
// Results appear on single-cycle rsp_valid strobes; the receiver cannot stall.
// Synchronous reset clears centers, sums, counts and sets num_clusters to 2.
// ----------------------------------------------------------------------------
module kmeans_centroid_update #(
   parameter int MAX_CLUSTERS = kmcu_pkg::DefMaxClusters,
   parameter int MAX_POINTS   = kmcu_pkg::DefMaxPoints
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [5:0]         req_cluster_index,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic               csr_write,
   input  logic [6:0]         csr_num_clusters,
   output logic               rsp_valid,
   output logic [5:0]         rsp_result_cluster,
   output logic signed [31:0] rsp_center_x,
   output logic signed [31:0] rsp_center_y,
   output logic               rsp_center_changed,
   output logic               rsp_cluster_empty,
   output logic               rsp_last_result
);
   import kmcu_pkg::*;

   localparam int IW = $clog2(MAX_CLUSTERS);

   logic [6:0]      k_ff;
   logic            in_xfer;
   kmcu_cmd_type    cmd;
   kmcu_status_type status;
   logic [IW-1:0]   walk_idx;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) k_ff <= 7'd2;
      else if (csr_write) k_ff <= csr_num_clusters;
   end

   assign in_xfer = start && !busy;

   kmcu_control #(.MAX_CLUSTERS(MAX_CLUSTERS), .IW(IW)) u_ctl (
      .clock(clock), .reset(reset),
      .finish(in_xfer && req_opcode == OP_FINISH),
      .num_clusters(k_ff), .status(status), .cmd(cmd), .walk_idx(walk_idx),
      .busy(busy), .rsp_valid(rsp_valid),
      .rsp_result_cluster(rsp_result_cluster), .rsp_last_result(rsp_last_result));

   kmcu_datapath #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_POINTS(MAX_POINTS), .IW(IW)) u_dp (
      .clock(clock), .reset(reset), .in_xfer(in_xfer),
      .req_opcode(req_opcode), .req_cluster_index(req_cluster_index),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .walk_idx(walk_idx), .cmd(cmd), .status(status),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_center_changed(rsp_center_changed), .rsp_cluster_empty(rsp_cluster_empty));
endmodule
